@@ sv/poxi_pkg.sv @@
// ----------------------------------------------------------------------------
// poxi_pkg
// Shared types and constants of the pulse oximeter sample processor.
// ----------------------------------------------------------------------------
`default_nettype none

package poxi_pkg;

  // input beat kinds
  localparam logic [1:0] MODE_SAMPLE   = 2'd0;
  localparam logic [1:0] MODE_BASELINE = 2'd1;
  localparam logic [1:0] MODE_WINDOW   = 2'd2;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FINGER_LOW      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FINGER_HIGH     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLOOR_LEVEL     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASELINE_RELOAD = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_RELOAD     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_MARGIN     = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STUCK_LIMIT     = 3'd6;

  // register reset values, truncated to the sample width where used
  localparam logic [31:0] FINGER_LOW_RST      = 32'd130000;
  localparam logic [31:0] FINGER_HIGH_RST     = 32'd170000;
  localparam logic [31:0] FLOOR_LEVEL_RST     = 32'd3000;
  localparam logic [31:0] BASELINE_RELOAD_RST = 32'd160000;
  localparam logic [31:0] PEAK_RELOAD_RST     = 32'd150000;
  localparam logic [31:0] PEAK_MARGIN_RST     = 32'd555;
  localparam logic [7:0]  STUCK_LIMIT_RST     = 8'd250;

  // SpO2 = 104 - 17*R in Q8.8: 26624 - round(4352*N/D)
  localparam int Q_BITS       = 17;
  localparam int SLOPE_SH_HI  = 13;  // 2*4352 = 2^13 + 2^9
  localparam int SLOPE_SH_LO  = 9;
  localparam logic signed [18:0] SPO2_OFFSET = 19'sd26624;
  localparam logic signed [18:0] SPO2_LIMIT  = 19'sd25600;
  localparam logic signed [18:0] SAT_POS     = 19'sd32767;
  localparam logic signed [18:0] SAT_NEG     = -19'sd32768;

  typedef struct packed {
    logic        below_floor;
    logic        div_zero;
    logic        red_neg;
    logic        finger;
    logic        lost;
    logic        beat_valid;
    logic [15:0] beat;
  } poxi_flags_t;

endpackage

`default_nettype wire

@@ sv/poxi_ifs.sv @@
// ----------------------------------------------------------------------------
// poxi_ifs
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface poxi_in_if #(
  parameter int SAMPLE_BITS = 18
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [SAMPLE_BITS-1:0] ir_sample;
  logic [SAMPLE_BITS-1:0] red_sample;

  modport source (output valid, mode, ir_sample, red_sample, input ready);
  modport sink   (input valid, mode, ir_sample, red_sample, output ready);
endinterface

interface poxi_out_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] spo2_value;
  logic               spo2_valid;
  logic               finger_present;
  logic               sensor_lost;
  logic [15:0]        beat_count;
  logic               beat_count_valid;

  modport source (output valid, spo2_value, spo2_valid, finger_present, sensor_lost,
                  beat_count, beat_count_valid, input ready);
  modport sink   (input valid, spo2_value, spo2_valid, finger_present, sensor_lost,
                  beat_count, beat_count_valid, output ready);
endinterface

`default_nettype wire

@@ sv/poxi_front.sv @@
// ----------------------------------------------------------------------------
// poxi_front
// Accepts beats, keeps minima, peak, window count and stuck run, and queues
// the ratio operands of each sample pair.
// ----------------------------------------------------------------------------
`default_nettype none

module poxi_front #(
  parameter int SAMPLE_BITS = 18,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [poxi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]              cfg_data,
  poxi_in_if.sink                                  smp,
  input  wire logic                                full,
  output logic                                     push,
  output poxi_pkg::poxi_flags_t                    flags,
  output logic [4*SAMPLE_BITS-1:0]                 job_data
);

  localparam int S = SAMPLE_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [S-1:0] finger_low, finger_high, floor_level, baseline_reload;
  logic [S-1:0] peak_reload, peak_margin;
  logic [7:0]   stuck_limit;

  logic [S-1:0]          ir_minimum, red_minimum, ir_peak, previous_ir;
  logic [COUNT_BITS-1:0] near_peak_count;
  logic                  report_pending;
  logic [7:0]            same_run_count;

  logic                  accept;
  logic [S-1:0]          ir, red;
  logic [S-1:0]          ir_min_next, red_min_next, peak_next;
  logic [S-1:0]          ir_diff, red_abs;
  logic                  above_floor, div_zero, red_neg, near, finger, lost;
  logic [COUNT_BITS-1:0] count_next;
  logic [31:0]           count_ext;
  logic [15:0]           beat;
  logic [7:0]            run_inc, run_next;
  logic                  same_ir;

  assign smp.ready = !full;
  assign accept    = smp.valid && !full;
  assign push      = accept && (smp.mode == poxi_pkg::MODE_SAMPLE);
  assign ir        = smp.ir_sample;
  assign red       = smp.red_sample;

  always_comb begin
    above_floor  = ir > floor_level;
    ir_min_next  = (ir < ir_minimum && above_floor) ? ir : ir_minimum;
    red_min_next = (red < red_minimum && red > floor_level) ? red : red_minimum;
    div_zero     = (ir == ir_min_next) || (red_min_next == '0);
    ir_diff      = ir - ir_min_next;
    red_neg      = red < red_min_next;
    red_abs      = red_neg ? (red_min_next - red) : (red - red_min_next);

    peak_next  = (ir > ir_peak) ? ir : ir_peak;
    near       = ({1'b0, ir} + {1'b0, peak_margin}) > {1'b0, peak_next};
    count_next = (near && near_peak_count != CMAX) ? near_peak_count + 1'b1
                                                   : near_peak_count;
    count_ext  = 32'(count_next);
    beat       = (count_ext > 32'hFFFF) ? 16'hFFFF : count_ext[15:0];

    same_ir  = previous_ir == ir;
    run_inc  = same_run_count + 8'd1;
    lost     = same_ir && (run_inc >= stuck_limit);
    run_next = (!same_ir || lost) ? 8'd0 : run_inc;

    finger = (ir > finger_low) && (ir < finger_high);

    flags.below_floor = !above_floor;
    flags.div_zero    = div_zero;
    flags.red_neg     = red_neg;
    flags.finger      = finger;
    flags.lost        = lost;
    flags.beat_valid  = report_pending;
    flags.beat        = report_pending ? beat : 16'd0;
    job_data          = {ir_min_next, red_min_next, ir_diff, red_abs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finger_low      <= poxi_pkg::FINGER_LOW_RST[S-1:0];
      finger_high     <= poxi_pkg::FINGER_HIGH_RST[S-1:0];
      floor_level     <= poxi_pkg::FLOOR_LEVEL_RST[S-1:0];
      baseline_reload <= poxi_pkg::BASELINE_RELOAD_RST[S-1:0];
      peak_reload     <= poxi_pkg::PEAK_RELOAD_RST[S-1:0];
      peak_margin     <= poxi_pkg::PEAK_MARGIN_RST[S-1:0];
      stuck_limit     <= poxi_pkg::STUCK_LIMIT_RST;
      ir_minimum      <= poxi_pkg::BASELINE_RELOAD_RST[S-1:0];
      red_minimum     <= poxi_pkg::BASELINE_RELOAD_RST[S-1:0];
      ir_peak         <= poxi_pkg::PEAK_RELOAD_RST[S-1:0];
      near_peak_count <= '0;
      report_pending  <= 1'b0;
      previous_ir     <= '0;
      same_run_count  <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          poxi_pkg::REG_FINGER_LOW:      finger_low      <= cfg_data;
          poxi_pkg::REG_FINGER_HIGH:     finger_high     <= cfg_data;
          poxi_pkg::REG_FLOOR_LEVEL:     floor_level     <= cfg_data;
          poxi_pkg::REG_BASELINE_RELOAD: baseline_reload <= cfg_data;
          poxi_pkg::REG_PEAK_RELOAD:     peak_reload     <= cfg_data;
          poxi_pkg::REG_PEAK_MARGIN:     peak_margin     <= cfg_data;
          poxi_pkg::REG_STUCK_LIMIT:     stuck_limit     <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (smp.mode)
          poxi_pkg::MODE_SAMPLE: begin
            ir_minimum      <= ir_min_next;
            red_minimum     <= red_min_next;
            ir_peak         <= peak_next;
            near_peak_count <= report_pending ? '0 : count_next;
            report_pending  <= 1'b0;
            previous_ir     <= ir;
            same_run_count  <= run_next;
          end
          poxi_pkg::MODE_BASELINE: begin
            ir_minimum  <= baseline_reload;
            red_minimum <= baseline_reload;
            ir_peak     <= peak_reload;
          end
          poxi_pkg::MODE_WINDOW: begin
            report_pending <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/poxi_queue.sv @@
// ----------------------------------------------------------------------------
// poxi_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module poxi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

@@ sv/poxi_back.sv @@
// ----------------------------------------------------------------------------
// poxi_back
// Forms N and D, divides with a rounding restoring divider and drives the
// registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module poxi_back #(
  parameter int SAMPLE_BITS = 18
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       empty,
  output logic                            pop,
  input  wire poxi_pkg::poxi_flags_t      flags,
  input  wire logic [4*SAMPLE_BITS-1:0]   job_data,
  poxi_out_if.source                      res
);

  localparam int S     = SAMPLE_BITS;
  localparam int QB    = poxi_pkg::Q_BITS;
  localparam int NUM_W = 2 * S + 14;
  localparam int REM_W = 2 * S + 1;
  localparam int CNT_W = $clog2(QB);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_CHK, S_DIV, S_FIN} state_t;

  state_t                state;
  poxi_pkg::poxi_flags_t job;
  logic [S-1:0]          ir_min, red_min, ir_diff, red_abs;
  logic [2*S-1:0]        mag, den;
  logic [NUM_W-1:0]      num;
  logic [REM_W-1:0]      den2, rem;
  logic [QB-1:0]         num_lo, quo;
  logic [CNT_W-1:0]      step;
  logic                  out_valid;
  logic signed [15:0]    spo2_value;
  logic                  spo2_valid, finger_present, sensor_lost, beat_count_valid;
  logic [15:0]           beat_count;

  logic [REM_W:0]        rem_sh, rem_sub;
  logic                  ge, out_free;
  logic signed [18:0]    qs, v, v_sat;
  logic signed [15:0]    spo_fin;
  logic                  valid_fin;

  assign pop      = (state == S_IDLE) && !empty;
  assign out_free = !out_valid || res.ready;

  always_comb begin
    rem_sh  = {rem, num_lo[QB-1]};
    rem_sub = rem_sh - {1'b0, den2};
    ge      = rem_sh >= {1'b0, den2};

    qs = $signed({2'b00, quo});
    v  = job.red_neg ? (poxi_pkg::SPO2_OFFSET + qs) : (poxi_pkg::SPO2_OFFSET - qs);
    if (v > poxi_pkg::SAT_POS) begin
      v_sat = poxi_pkg::SAT_POS;
    end else if (v < poxi_pkg::SAT_NEG) begin
      v_sat = poxi_pkg::SAT_NEG;
    end else begin
      v_sat = v;
    end
    if (job.below_floor) begin
      spo_fin   = 16'sd0;
      valid_fin = !job.div_zero;
    end else if (job.div_zero) begin
      spo_fin   = 16'sd0;
      valid_fin = 1'b0;
    end else begin
      spo_fin   = v_sat[15:0];
      valid_fin = !v_sat[18] && (v_sat < poxi_pkg::SPO2_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            job                              <= flags;
            {ir_min, red_min, ir_diff, red_abs} <= job_data;
            state <= (flags.below_floor || flags.div_zero) ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          mag   <= ir_min * red_abs;
          den   <= ir_diff * red_min;
          state <= S_SUM;
        end
        S_SUM: begin
          num   <= (NUM_W'(mag) << poxi_pkg::SLOPE_SH_HI)
                 + (NUM_W'(mag) << poxi_pkg::SLOPE_SH_LO) + NUM_W'(den);
          den2  <= {den, 1'b0};
          state <= S_CHK;
        end
        S_CHK: begin
          num_lo <= num[QB-1:0];
          step   <= CNT_W'(QB - 1);
          if (REM_W'(num[NUM_W-1:QB]) >= den2) begin
            quo   <= '1;
            state <= S_FIN;
          end else begin
            rem   <= REM_W'(num[NUM_W-1:QB]);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
          quo    <= {quo[QB-2:0], ge};
          num_lo <= {num_lo[QB-2:0], 1'b0};
          step   <= step - 1'b1;
          if (step == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            spo2_value       <= spo_fin;
            spo2_valid       <= valid_fin;
            finger_present   <= job.finger;
            sensor_lost      <= job.lost;
            beat_count       <= job.beat;
            beat_count_valid <= job.beat_valid;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid            = out_valid;
  assign res.spo2_value       = spo2_value;
  assign res.spo2_valid       = spo2_valid;
  assign res.finger_present   = finger_present;
  assign res.sensor_lost      = sensor_lost;
  assign res.beat_count       = beat_count;
  assign res.beat_count_valid = beat_count_valid;

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den2))
    else $error("divider remainder not below divisor");
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished job did not produce a result beat");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != S_IDLE))
    else $error("job popped but back stayed idle");

endmodule

`default_nettype wire

@@ sv/pulse_oximeter_sample_processor_top.sv @@
// ----------------------------------------------------------------------------
// pulse_oximeter_sample_processor_top
// SpO2 ratio-of-ratios processor for infrared/red sample pairs.
// ----------------------------------------------------------------------------
// The front takes one beat per cycle while its two-entry job queue has room;
// baseline and window-end events finish in that cycle and give no result.
// Each sample pair gives one result beat. In the back, a pair at or below the
// floor or with a zero divisor goes from issue to the output register, a pair
// whose quotient does not fit 17 bits (saturated reading) goes there from the
// range check, and any other pair passes through issue, two 18x18 multiplies,
// scaled sum, range check, a restoring divider that yields one of 17 quotient
// bits per cycle, and the output register. The divider bounds the sample
// rate: the back takes a new pair only when idle. Configuration writes take
// effect at the next edge and must be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_oximeter_sample_processor_top #(
  parameter int SAMPLE_BITS = 18,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [poxi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]              cfg_data,
  poxi_in_if.sink                                  sample_in,
  poxi_out_if.source                               result_out
);

  localparam int FLAGS_W = $bits(poxi_pkg::poxi_flags_t);
  localparam int DATA_W  = 4 * SAMPLE_BITS;
  localparam int JOB_W   = FLAGS_W + DATA_W;

  logic                  push, pop, full, empty;
  poxi_pkg::poxi_flags_t front_flags, back_flags;
  logic [DATA_W-1:0]     front_data, back_data;
  logic [JOB_W-1:0]      q_rd;

  poxi_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .smp       (sample_in),
    .full      (full),
    .push      (push),
    .flags     (front_flags),
    .job_data  (front_data)
  );

  poxi_queue #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data ({front_flags, front_data}),
    .full    (full),
    .pop     (pop),
    .rd_data (q_rd),
    .empty   (empty)
  );

  assign back_flags = q_rd[JOB_W-1:DATA_W];
  assign back_data  = q_rd[DATA_W-1:0];

  poxi_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop      (pop),
    .flags    (back_flags),
    .job_data (back_data),
    .res      (result_out)
  );

endmodule

`default_nettype wire
